// File: hw/rtl/stts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stts_pkg
// Shared types, codes and keyword tables for the source text token scanner.
// ----------------------------------------------------------------------------
package stts_pkg;

  localparam int KwCount    = 20;
  localparam int KwMaxLen   = 9;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_type;
    logic [5:0] token_kind;
    logic [7:0] text_byte;
    logic [3:0] error_code;
    logic       last;
  } out_item_t;

  // One front-end step: up to two results.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } step_t;

  localparam logic [1:0] TypeText  = 2'd0;
  localparam logic [1:0] TypeToken = 2'd1;
  localparam logic [1:0] TypeError = 2'd2;

  localparam logic [5:0] TkPlus   = 6'd0;
  localparam logic [5:0] TkMinus  = 6'd1;
  localparam logic [5:0] TkMul    = 6'd2;
  localparam logic [5:0] TkDiv    = 6'd3;
  localparam logic [5:0] TkLpar   = 6'd4;
  localparam logic [5:0] TkRpar   = 6'd5;
  localparam logic [5:0] TkComma  = 6'd6;
  localparam logic [5:0] TkSemi   = 6'd7;
  localparam logic [5:0] TkLbrace = 6'd8;
  localparam logic [5:0] TkRbrace = 6'd9;
  localparam logic [5:0] TkEol    = 6'd10;
  localparam logic [5:0] TkEof    = 6'd11;
  localparam logic [5:0] TkAssign = 6'd12;
  localparam logic [5:0] TkEq     = 6'd13;
  localparam logic [5:0] TkLt     = 6'd14;
  localparam logic [5:0] TkLe     = 6'd15;
  localparam logic [5:0] TkGt     = 6'd16;
  localparam logic [5:0] TkGe     = 6'd17;
  localparam logic [5:0] TkNe     = 6'd18;
  localparam logic [5:0] TkDefine = 6'd19;
  localparam logic [5:0] TkIdent  = 6'd20;
  localparam logic [5:0] TkInt    = 6'd21;
  localparam logic [5:0] TkFloat  = 6'd22;
  localparam logic [5:0] TkString = 6'd23;
  localparam logic [5:0] TkKwBase = 6'd24;

  localparam logic [3:0] ErrUnknown  = 4'd0;
  localparam logic [3:0] ErrZero     = 4'd1;
  localparam logic [3:0] ErrBang     = 4'd2;
  localparam logic [3:0] ErrColon    = 4'd3;
  localparam logic [3:0] ErrDot      = 4'd4;
  localparam logic [3:0] ErrExp      = 4'd5;
  localparam logic [3:0] ErrExpDot   = 4'd6;
  localparam logic [3:0] ErrStrEnd   = 4'd7;
  localparam logic [3:0] ErrStrCtl   = 4'd8;
  localparam logic [3:0] ErrEscape   = 4'd9;
  localparam logic [3:0] ErrHex      = 4'd10;
  localparam logic [3:0] ErrComment  = 4'd11;

  typedef logic [KwMaxLen*8-1:0] kw_text_t;

  // Keyword text, first character in the low byte.
  function automatic kw_text_t kw_text(input logic [4:0] idx);
    kw_text_t t;
    t = '0;
    unique case (idx)
      5'd0:  t = kw_text_t'("cnuf");
      5'd1:  t = kw_text_t'("nruter");
      5'd2:  t = kw_text_t'("46taolf");
      5'd3:  t = kw_text_t'("tni");
      5'd4:  t = kw_text_t'("gnirts");
      5'd5:  t = kw_text_t'("rof");
      5'd6:  t = kw_text_t'("fi");
      5'd7:  t = kw_text_t'("esle");
      5'd8:  t = kw_text_t'("egakcap");
      5'd9:  t = kw_text_t'("niam");
      5'd10: t = kw_text_t'("stupni");
      5'd11: t = kw_text_t'("itupni");
      5'd12: t = kw_text_t'("ftupni");
      5'd13: t = kw_text_t'("tnirp");
      5'd14: t = kw_text_t'("taolf2tni");
      5'd15: t = kw_text_t'("tni2taolf");
      5'd16: t = kw_text_t'("nel");
      5'd17: t = kw_text_t'("rtsbus");
      5'd18: t = kw_text_t'("dro");
      5'd19: t = kw_text_t'("rhc");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [3:0] l;
    l = 4'd0;
    unique case (idx)
      5'd0, 5'd7, 5'd9:                          l = 4'd4;
      5'd1, 5'd4, 5'd10, 5'd11, 5'd12, 5'd17:    l = 4'd6;
      5'd2, 5'd8:                                l = 4'd7;
      5'd3, 5'd5, 5'd16, 5'd18, 5'd19:           l = 4'd3;
      5'd6:                                      l = 4'd2;
      5'd13:                                     l = 4'd5;
      5'd14, 5'd15:                              l = 4'd9;
      default:                                   l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

// File: hw/rtl/stts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stts_front
// Scanner state machine: takes one byte a cycle while step_en is high and forms up to two results.
// ----------------------------------------------------------------------------
module stts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  stts_pkg::in_item_t item,
  output stts_pkg::step_t   step
);

  typedef enum logic [4:0] {
    Q_START, Q_ASSIGN, Q_LESS, Q_GREAT, Q_BANG, Q_COLON, Q_SLASH, Q_LINEC,
    Q_BLOCK, Q_BSTAR, Q_IDENT, Q_WORD, Q_INT, Q_ZERO, Q_DOT, Q_FRAC, Q_EXP,
    Q_ESIGN, Q_EDIG, Q_STR, Q_ESC, Q_HEX1, Q_HEX2
  } state_t;

  state_t                        state_r, state_nxt;
  logic [stts_pkg::KwCount-1:0]  alive_r, alive_nxt;
  logic [3:0]                    pos_r, pos_nxt;
  logic [3:0]                    hex_r, hex_nxt;

  logic [7:0] c;
  logic       eoi;
  logic       dig, alpha, hexd;
  logic [3:0] hval;
  logic [stts_pkg::KwCount-1:0] kw_keep, start_keep;
  logic [5:0] kw_kind;
  logic [7:0] hv;

  assign c     = item.in_byte;
  assign eoi   = item.end_of_input;
  assign dig   = !eoi && c >= "0" && c <= "9";
  assign alpha = !eoi && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
  assign hexd  = dig || (!eoi && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
  assign hval  = (c >= "0" && c <= "9") ? c[3:0] : 4'(c[3:0] + 4'd9);
  assign hv    = {hex_r, hval};

  // Keyword filters for continuing and for a fresh word.
  always_comb begin
    stts_pkg::kw_text_t t;
    for (int i = 0; i < stts_pkg::KwCount; i++) begin
      t = stts_pkg::kw_text(5'(i));
      kw_keep[i] = alive_r[i] && (pos_r < stts_pkg::kw_len(5'(i))) &&
                   (pos_r < 4'(stts_pkg::KwMaxLen)) && (t[pos_r*8 +: 8] == c);
      start_keep[i] = (t[7:0] == c);
    end
  end

  always_comb begin
    kw_kind = stts_pkg::TkIdent;
    for (int i = stts_pkg::KwCount - 1; i >= 0; i--) begin
      if (alive_r[i] && stts_pkg::kw_len(5'(i)) == pos_r) begin
        kw_kind = 6'(stts_pkg::TkKwBase + 6'(i));
      end
    end
  end

  always_comb begin
    logic [1:0]          n;
    stts_pkg::out_item_t r0, r1, e;
    logic                restart;
    logic [5:0]          fin;
    n = 2'd0; r0 = '0; r1 = '0; e = '0;
    restart = 1'b0;
    fin = '0;
    state_nxt = state_r;
    alive_nxt = alive_r;
    pos_nxt   = pos_r;
    hex_nxt   = hex_r;

    // First result of the step; restart may add a second one below.
    unique case (state_r)
      Q_ASSIGN, Q_LESS, Q_GREAT: begin
        if (!eoi && c == "=") begin
          n = 2'd1; r0.out_type = stts_pkg::TypeToken;
          r0.token_kind = (state_r == Q_ASSIGN) ? stts_pkg::TkEq :
                          (state_r == Q_LESS) ? stts_pkg::TkLe : stts_pkg::TkGe;
          state_nxt = Q_START;
        end else begin
          restart = 1'b1;
          fin = (state_r == Q_ASSIGN) ? stts_pkg::TkAssign :
                (state_r == Q_LESS) ? stts_pkg::TkLt : stts_pkg::TkGt;
        end
      end
      Q_BANG, Q_COLON: begin
        n = 2'd1;
        state_nxt = Q_START;
        if (!eoi && c == "=") begin
          r0.out_type = stts_pkg::TypeToken;
          r0.token_kind = (state_r == Q_BANG) ? stts_pkg::TkNe : stts_pkg::TkDefine;
        end else begin
          r0.out_type = stts_pkg::TypeError;
          r0.error_code = (state_r == Q_BANG) ? stts_pkg::ErrBang : stts_pkg::ErrColon;
        end
      end
      Q_SLASH: begin
        if (!eoi && c == "/") state_nxt = Q_LINEC;
        else if (!eoi && c == "*") state_nxt = Q_BLOCK;
        else begin restart = 1'b1; fin = stts_pkg::TkDiv; end
      end
      Q_LINEC: begin
        if (eoi || c == 8'h0a) begin restart = 1'b1; fin = '1; end
      end
      Q_BLOCK, Q_BSTAR: begin
        if (eoi) begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrComment; state_nxt = Q_START;
        end else if (c == "*") state_nxt = Q_BSTAR;
        else if (state_r == Q_BSTAR && c == "/") state_nxt = Q_START;
        else state_nxt = Q_BLOCK;
      end
      Q_IDENT: begin
        if (alpha || dig || (!eoi && c == "_")) begin
          n = 2'd1; r0.text_byte = c;
        end else begin restart = 1'b1; fin = stts_pkg::TkIdent; end
      end
      Q_WORD: begin
        if (alpha || dig) begin
          n = 2'd1; r0.text_byte = c;
          alive_nxt = kw_keep;
          pos_nxt = (pos_r < 4'd15) ? 4'(pos_r + 4'd1) : 4'd15;
        end else if (!eoi && c == "_") begin
          n = 2'd1; r0.text_byte = c; state_nxt = Q_IDENT;
        end else begin restart = 1'b1; fin = kw_kind; end
      end
      Q_ZERO, Q_INT: begin
        if (state_r == Q_ZERO && dig) begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrZero; state_nxt = Q_START;
        end else if (!eoi && c == ".") begin
          n = 2'd1; r0.text_byte = c; state_nxt = Q_DOT;
        end else if (!eoi && (c == "e" || c == "E")) begin
          n = 2'd1; r0.text_byte = c; state_nxt = Q_EXP;
        end else if (dig) begin
          n = 2'd1; r0.text_byte = c; state_nxt = Q_INT;
        end else begin restart = 1'b1; fin = stts_pkg::TkInt; end
      end
      Q_DOT: begin
        n = 2'd1;
        if (dig) begin r0.text_byte = c; state_nxt = Q_FRAC; end
        else begin
          r0.out_type = stts_pkg::TypeError; r0.error_code = stts_pkg::ErrDot;
          state_nxt = Q_START;
        end
      end
      Q_FRAC: begin
        if (dig) begin n = 2'd1; r0.text_byte = c; end
        else if (!eoi && (c == "e" || c == "E")) begin
          n = 2'd1; r0.text_byte = c; state_nxt = Q_EXP;
        end else begin restart = 1'b1; fin = stts_pkg::TkFloat; end
      end
      Q_EXP, Q_ESIGN: begin
        n = 2'd1;
        if (dig) begin r0.text_byte = c; state_nxt = Q_EDIG; end
        else if (state_r == Q_EXP && !eoi && (c == "+" || c == "-")) begin
          r0.text_byte = c; state_nxt = Q_ESIGN;
        end else begin
          r0.out_type = stts_pkg::TypeError; r0.error_code = stts_pkg::ErrExp;
          state_nxt = Q_START;
        end
      end
      Q_EDIG: begin
        if (dig) begin n = 2'd1; r0.text_byte = c; end
        else if (!eoi && c == ".") begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrExpDot; state_nxt = Q_START;
        end else begin restart = 1'b1; fin = stts_pkg::TkFloat; end
      end
      Q_STR: begin
        priority if (!eoi && c == "\"") begin
          n = 2'd1; r0.out_type = stts_pkg::TypeToken;
          r0.token_kind = stts_pkg::TkString; state_nxt = Q_START;
        end else if (eoi || c == 8'h0a) begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrStrEnd; state_nxt = Q_START;
        end else if (c <= 8'd31) begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrStrCtl; state_nxt = Q_START;
        end else if (c == "\\") state_nxt = Q_ESC;
        else begin n = 2'd1; r0.text_byte = c; end
      end
      Q_ESC: begin
        n = 2'd1;
        state_nxt = Q_STR;
        priority if (eoi || c == 8'h0a) begin
          r0.out_type = stts_pkg::TypeError; r0.error_code = stts_pkg::ErrStrEnd;
          state_nxt = Q_START;
        end else if (c == "\"") r0.text_byte = c;
        else if (c == "n") r0.text_byte = 8'h0a;
        else if (c == "t") r0.text_byte = 8'h09;
        else if (c == "\\") r0.text_byte = c;
        else if (c == "x") begin n = 2'd0; state_nxt = Q_HEX1; end
        else begin
          r0.out_type = stts_pkg::TypeError; r0.error_code = stts_pkg::ErrEscape;
          state_nxt = Q_START;
        end
      end
      Q_HEX1: begin
        if (hexd) begin hex_nxt = hval; state_nxt = Q_HEX2; end
        else begin
          n = 2'd1; r0.out_type = stts_pkg::TypeError;
          r0.error_code = stts_pkg::ErrHex; state_nxt = Q_START;
        end
      end
      Q_HEX2: begin
        n = 2'd1;
        if (hexd && hv != 8'd0) begin r0.text_byte = hv; state_nxt = Q_STR; end
        else begin
          r0.out_type = stts_pkg::TypeError; r0.error_code = stts_pkg::ErrHex;
          state_nxt = Q_START;
        end
      end
      default: begin restart = 1'b1; fin = '1; end
    endcase

    // Pending token ends: emit it (unless from comment/start) then rescan.
    if (restart) begin
      if (fin != '1) begin
        n = 2'd1; r0 = '0; r0.out_type = stts_pkg::TypeToken; r0.token_kind = fin;
      end
      e = '0;
      state_nxt = Q_START;
      priority if (eoi) begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkEof; end
      else if (c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d) e.last = 1'b1;
      else if (c == 8'h0a) begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkEol; end
      else if (c == "+") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkPlus; end
      else if (c == "-") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkMinus; end
      else if (c == "*") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkMul; end
      else if (c == "(") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkLpar; end
      else if (c == ")") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkRpar; end
      else if (c == ",") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkComma; end
      else if (c == ";") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkSemi; end
      else if (c == "{") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkLbrace; end
      else if (c == "}") begin e.out_type = stts_pkg::TypeToken; e.token_kind = stts_pkg::TkRbrace; end
      else if (c == "/") begin e.last = 1'b1; state_nxt = Q_SLASH; end
      else if (c == "=") begin e.last = 1'b1; state_nxt = Q_ASSIGN; end
      else if (c == "<") begin e.last = 1'b1; state_nxt = Q_LESS; end
      else if (c == ">") begin e.last = 1'b1; state_nxt = Q_GREAT; end
      else if (c == "!") begin e.last = 1'b1; state_nxt = Q_BANG; end
      else if (c == ":") begin e.last = 1'b1; state_nxt = Q_COLON; end
      else if (c == "\"") begin e.last = 1'b1; state_nxt = Q_STR; end
      else if (c == "_") begin e.text_byte = c; state_nxt = Q_IDENT; end
      else if (alpha) begin
        e.text_byte = c; alive_nxt = start_keep; pos_nxt = 4'd1; state_nxt = Q_WORD;
      end else if (dig) begin
        e.text_byte = c; state_nxt = (c == "0") ? Q_ZERO : Q_INT;
      end else begin e.out_type = stts_pkg::TypeError; e.error_code = stts_pkg::ErrUnknown; end
      // e.last marks "no result" here; clear it after use.
      if (!e.last) begin
        if (n == 2'd0) r0 = e; else r1 = e;
        n = 2'(n + 2'd1);
      end
      r1.last = 1'b0;
      r0.last = 1'b0;
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
    step.count = n;
    step.res0  = r0;
    step.res1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_START;
      alive_r <= '0;
      pos_r   <= '0;
      hex_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      alive_r <= alive_nxt;
      pos_r   <= pos_nxt;
      hex_r   <= hex_nxt;
    end
  end

endmodule

// File: hw/rtl/stts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stts_queue
// Result queue: takes zero to two results a cycle, gives one a cycle when read and not empty.
// ----------------------------------------------------------------------------
module stts_queue #(
  parameter int Depth = stts_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  stts_pkg::step_t     wr_step,
  input  logic                rd_en,
  output stts_pkg::out_item_t rd_item,
  output logic                empty,
  output logic                room2
);

  localparam int Aw = $clog2(Depth);

  stts_pkg::out_item_t    mem_r [Depth];
  logic [Aw-1:0]          wp_r, rp_r;
  logic [Aw:0]            cnt_r, cnt_nxt;
  logic [1:0]             n;

  assign n       = wr_en ? wr_step.count : 2'd0;
  assign empty   = (cnt_r == '0);
  assign room2   = (cnt_r <= (Aw+1)'(Depth - 2));
  assign rd_item = mem_r[rp_r];
  assign cnt_nxt = (Aw+1)'(cnt_r + (Aw+1)'(n) - (Aw+1)'(rd_en && !empty));

  always_ff @(posedge clk) begin
    if (n != 2'd0) mem_r[wp_r] <= wr_step.res0;
    if (n == 2'd2) mem_r[Aw'(wp_r + Aw'(1))] <= wr_step.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= Aw'(wp_r + Aw'(n));
      if (rd_en && !empty) rp_r <= Aw'(rp_r + Aw'(1));
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/source_text_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_token_scanner
// Byte-serial lexer: source bytes in, text bytes, tokens and errors out.
//
//   channel | handshake    | payload
//   input   | push / full  | in_item  (in_byte, end_of_input)
//   result  | pop / empty  | out_item (out_type, token_kind, text_byte, ...)
//
// One byte is scanned per cycle while full is low; each byte gives up to two results,
// written into a small result queue that is read one per cycle while pop is high.
// full is raised while the queue cannot take two more results.
// Reset clears the scanner state and empties the queue.
// A stalled result side only stops input once the queue fills.
// ----------------------------------------------------------------------------
module source_text_token_scanner #(
  parameter int QueueDepth = stts_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  stts_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output stts_pkg::out_item_t out_item
);

  stts_pkg::step_t step;
  logic            room2;
  logic            accept;

  assign full   = !room2;
  assign accept = push && !full;

  stts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .item    (in_item),
    .step    (step)
  );

  stts_queue #(.Depth(QueueDepth)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_step (step),
    .rd_en   (pop),
    .rd_item (out_item),
    .empty   (empty),
    .room2   (room2)
  );

  a_no_three: assert property (@(posedge clk) disable iff (!rst_n)
    step.count != 2'd3) else $error("more than two results in one step");
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (step.count == 2'd2) |-> (step.res1.last && !step.res0.last))
    else $error("last flag misplaced");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full) else $error("full dropped without a transfer out");

endmodule

// File: verif/source_text_token_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_token_scanner_test
// Feeds directed and random source text to the scanner through its push/full
// port and checks every text byte, token and error against a behavioural
// lexer model held in a small scoreboard class.
// ----------------------------------------------------------------------------
module source_text_token_scanner_test;

  typedef enum logic [4:0] {
    LxStart, LxAssign, LxLess, LxGreat, LxBang, LxColon, LxSlash, LxLineCmt,
    LxBlock, LxBlockStar, LxIdent, LxWord, LxInt, LxZero, LxDot, LxFrac,
    LxExp, LxExpSign, LxExpDig, LxStr, LxEsc, LxHex1, LxHex2
  } lex_state_t;

  localparam int NumKw = 20;
  localparam int MaxShown = 10;

  class lexer_scoreboard;
    lex_state_t lx;
    logic [19:0] kw_live;
    logic [3:0]  kw_pos;
    logic [3:0]  hex_hi;
    stts_pkg::out_item_t pending[$];
    int          step_n;
    int          mismatches;
    string       kw_names[NumKw];

    function new();
      kw_names = '{"func", "return", "float64", "int", "string", "for", "if",
                   "else", "package", "main", "inputs", "inputi", "inputf",
                   "print", "int2float", "float2int", "len", "substr", "ord",
                   "chr"};
      lx = LxStart; kw_live = '0; kw_pos = '0; hex_hi = '0;
      mismatches = 0;
    endfunction

    function void put(logic [1:0] ty, logic [5:0] k, logic [7:0] b, logic [3:0] e);
      stts_pkg::out_item_t r;
      if (step_n >= 2) return;
      r.out_type = ty; r.token_kind = k; r.text_byte = b; r.error_code = e;
      r.last = 1'b0;
      pending.push_back(r);
      step_n++;
    endfunction

    function void tok(logic [5:0] k); put(stts_pkg::TypeToken, k, 8'd0, 4'd0); endfunction
    function void txt(int b); put(stts_pkg::TypeText, 6'd0, 8'(b), 4'd0); endfunction
    function void err(logic [3:0] e);
      put(stts_pkg::TypeError, 6'd0, 8'd0, e); lx = LxStart;
    endfunction

    function bit is_dig(int c); return c >= "0" && c <= "9"; endfunction
    function bit is_alpha(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function bit is_hex(int c);
      return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function logic [3:0] hex_of(int c);
      if (is_dig(c)) return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'(c - "A" + 10);
    endfunction

    function void kw_step(int c);
      logic [19:0] keep;
      keep = '0;
      for (int i = 0; i < NumKw; i++)
        if (kw_live[i] && kw_pos < kw_names[i].len() && kw_names[i][kw_pos] == c)
          keep[i] = 1'b1;
      kw_live = keep;
      if (kw_pos < 15) kw_pos++;
    endfunction

    function logic [5:0] word_kind();
      for (int i = 0; i < NumKw; i++)
        if (kw_live[i] && kw_names[i].len() == kw_pos)
          return 6'(stts_pkg::TkKwBase + 6'(i));
      return stts_pkg::TkIdent;
    endfunction

    // c is 256 for end of input
    function void from_start(int c);
      lx = LxStart;
      case (c)
        256: tok(stts_pkg::TkEof);
        " ", 9, 11, 12, 13: ;
        10: tok(stts_pkg::TkEol);
        "+": tok(stts_pkg::TkPlus);
        "-": tok(stts_pkg::TkMinus);
        "*": tok(stts_pkg::TkMul);
        "(": tok(stts_pkg::TkLpar);
        ")": tok(stts_pkg::TkRpar);
        ",": tok(stts_pkg::TkComma);
        ";": tok(stts_pkg::TkSemi);
        "{": tok(stts_pkg::TkLbrace);
        "}": tok(stts_pkg::TkRbrace);
        "/": lx = LxSlash;
        "=": lx = LxAssign;
        "<": lx = LxLess;
        ">": lx = LxGreat;
        "!": lx = LxBang;
        ":": lx = LxColon;
        34: lx = LxStr;
        "_": begin txt(c); lx = LxIdent; end
        default: begin
          if (is_alpha(c)) begin
            txt(c); kw_live = '1; kw_pos = 0; kw_step(c); lx = LxWord;
          end else if (is_dig(c)) begin
            txt(c); lx = (c == "0") ? LxZero : LxInt;
          end else begin
            err(stts_pkg::ErrUnknown);
          end
        end
      endcase
    endfunction

    function void close(logic [5:0] k, int c); tok(k); from_start(c); endfunction

    function void note_input(stts_pkg::in_item_t it);
      int c;
      int first;
      logic [7:0] v;
      c = it.end_of_input ? 256 : it.in_byte;
      first = pending.size();
      step_n = 0;
      case (lx)
        LxAssign: begin
          if (c == "=") begin tok(stts_pkg::TkEq); lx = LxStart; end
          else close(stts_pkg::TkAssign, c);
        end
        LxLess: begin
          if (c == "=") begin tok(stts_pkg::TkLe); lx = LxStart; end
          else close(stts_pkg::TkLt, c);
        end
        LxGreat: begin
          if (c == "=") begin tok(stts_pkg::TkGe); lx = LxStart; end
          else close(stts_pkg::TkGt, c);
        end
        LxBang: begin
          if (c == "=") begin tok(stts_pkg::TkNe); lx = LxStart; end
          else err(stts_pkg::ErrBang);
        end
        LxColon: begin
          if (c == "=") begin tok(stts_pkg::TkDefine); lx = LxStart; end
          else err(stts_pkg::ErrColon);
        end
        LxSlash: begin
          if (c == "/") lx = LxLineCmt;
          else if (c == "*") lx = LxBlock;
          else close(stts_pkg::TkDiv, c);
        end
        LxLineCmt: if (c == 10 || c == 256) from_start(c);
        LxBlock: begin
          if (c == "*") lx = LxBlockStar;
          else if (c == 256) err(stts_pkg::ErrComment);
        end
        LxBlockStar: begin
          if (c == "/") lx = LxStart;
          else if (c == 256) err(stts_pkg::ErrComment);
          else if (c != "*") lx = LxBlock;
        end
        LxIdent: begin
          if (is_alpha(c) || is_dig(c) || c == "_") txt(c);
          else close(stts_pkg::TkIdent, c);
        end
        LxWord: begin
          if (is_alpha(c) || is_dig(c)) begin txt(c); kw_step(c); end
          else if (c == "_") begin txt(c); lx = LxIdent; end
          else close(word_kind(), c);
        end
        LxZero, LxInt: begin
          if (lx == LxZero && is_dig(c)) err(stts_pkg::ErrZero);
          else if (c == ".") begin txt(c); lx = LxDot; end
          else if (c == "e" || c == "E") begin txt(c); lx = LxExp; end
          else if (is_dig(c)) begin txt(c); lx = LxInt; end
          else close(stts_pkg::TkInt, c);
        end
        LxDot: if (is_dig(c)) begin txt(c); lx = LxFrac; end else err(stts_pkg::ErrDot);
        LxFrac: begin
          if (is_dig(c)) txt(c);
          else if (c == "e" || c == "E") begin txt(c); lx = LxExp; end
          else close(stts_pkg::TkFloat, c);
        end
        LxExp: begin
          if (is_dig(c)) begin txt(c); lx = LxExpDig; end
          else if (c == "+" || c == "-") begin txt(c); lx = LxExpSign; end
          else err(stts_pkg::ErrExp);
        end
        LxExpSign: begin
          if (is_dig(c)) begin txt(c); lx = LxExpDig; end
          else err(stts_pkg::ErrExp);
        end
        LxExpDig: begin
          if (is_dig(c)) txt(c);
          else if (c == ".") err(stts_pkg::ErrExpDot);
          else close(stts_pkg::TkFloat, c);
        end
        LxStr: begin
          if (c == 34) begin tok(stts_pkg::TkString); lx = LxStart; end
          else if (c == 10 || c == 256) err(stts_pkg::ErrStrEnd);
          else if (c <= 31) err(stts_pkg::ErrStrCtl);
          else if (c == 92) lx = LxEsc;
          else txt(c);
        end
        LxEsc: begin
          if (c == 10 || c == 256) err(stts_pkg::ErrStrEnd);
          else if (c == 34) begin txt(34); lx = LxStr; end
          else if (c == "n") begin txt(10); lx = LxStr; end
          else if (c == "t") begin txt(9); lx = LxStr; end
          else if (c == 92) begin txt(92); lx = LxStr; end
          else if (c == "x") lx = LxHex1;
          else err(stts_pkg::ErrEscape);
        end
        LxHex1: begin
          if (is_hex(c)) begin hex_hi = hex_of(c); lx = LxHex2; end
          else err(stts_pkg::ErrHex);
        end
        LxHex2: begin
          if (is_hex(c)) begin
            v = {hex_hi, hex_of(c)};
            if (v == 0) err(stts_pkg::ErrHex); else begin txt(v); lx = LxStr; end
          end else err(stts_pkg::ErrHex);
        end
        default: from_start(c);
      endcase
      if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(stts_pkg::out_item_t got);
      stts_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  stts_pkg::in_item_t in_item = '0;
  stts_pkg::out_item_t out_item;

  lexer_scoreboard lexer = new();
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int sent = 0;

  source_text_token_scanner dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // note transfers at the edge, from the values driven before it
  always @(posedge clk) begin
    if (rst_n && push && !full) lexer.note_input(in_item);
    if (rst_n && pop && !empty) lexer.check_result(out_item);
  end

  task automatic send_byte(input int c);
    stts_pkg::in_item_t it;
    it.end_of_input = (c == 256);
    it.in_byte = (c == 256) ? 8'($urandom) : 8'(c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string pick(input string opts[]);
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  function automatic string rand_lexeme();
    string s;
    int n;
    string kws[] = '{"func", "return", "float64", "int", "string", "for", "if",
                     "else", "package", "main", "inputs", "inputi", "inputf",
                     "print", "int2float", "float2int", "len", "substr", "ord",
                     "chr", "fun", "inty", "x_1", "_a", "Zq9"};
    string ops[] = '{"+", "-", "*", "/", "(", ")", ",", ";", "{", "}", "=", "==",
                     "<", "<=", ">", ">=", "!=", ":=", "!", ":", "\n", " ", "\t"};
    string nums[] = '{"0", "7", "05", "123", "1.5", "1.", "2e9", "3E+4", "4e-",
                      "5e", "6.25e1", "7e2.", "0.0", "9x", "0e1"};
    string strs[] = '{"\"ab\"", "\"q\\n\\t\\\\\\\"\"", "\"\\x41\\xfF\"", "\"\\x00\"",
                      "\"\\xg\"", "\"\\x4z\"", "\"\\q\"", "\"ab\n", "\"\\\n",
                      "\"\x01\"", "\"\xc3\xa9\""};
    string cmts[] = '{"// note\n", "/* a * b **/", "/***/", "/* x */", "//\n"};
    case ($urandom_range(0, 9))
      0, 1, 2: return pick(kws);
      3, 4: return pick(ops);
      5: return pick(nums);
      6: return pick(strs);
      7: return pick(cmts);
      8: begin
        s = "";
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
      end
      default: return " ";
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: operators, keywords, numbers, strings, comments and errors
    send_text("func main(){x:=y<=z>=w!=v==u;a=b<c>d+1-2*3/4,}\n");
    send_text("int2float substr _k9 0 09 1.e 2e+x 3e2. \"\\xfa\x80\" ");
    send_text("! : # \"\t\" \"\\x00\"/* * / **/ // c");
    send_byte(256);
    send_byte(0);
    send_byte(255);
    send_text("/* open");
    send_byte(256);
    // random: mostly well-formed lexemes, some bare noise and ends of input
    while (sent < 1950) begin
      if (sent > 1650) calm = 1'b1;
      if ($urandom_range(0, 40) == 0) send_byte(256);
      else if ($urandom_range(0, 12) == 0) send_byte($urandom_range(0, 255));
      else send_text(rand_lexeme());
      send_byte(" ");
    end
    send_byte(256);
    push <= 1'b0;
  end

  initial begin
    int lull;
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    // hold the result side so the queue fills and input stalls
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
    forever begin
      if (!hold_off && !calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        lull = $urandom_range(1, 3);
        repeat (lull) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    wait (rst_n && calm && !push);
    while (lexer.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lexer.mismatches == 0 && lexer.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
